@@ rtl/core/txra_pkg.sv @@
// ----------------------------------------------------------------------------
// txra_pkg
// Shared constants, codes and controller/datapath interface types for the
// transmit ring frame admission block.
// ----------------------------------------------------------------------------
package txra_pkg;

   localparam int DEPTH     = 1024;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int SIZE_W    = IDX_W + 1;

   localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(DEPTH);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(DEPTH);

   localparam logic [1:0] KIND_HEADER   = 2'd0;
   localparam logic [1:0] KIND_DATA     = 2'd1;
   localparam logic [1:0] KIND_COMPLETE = 2'd2;
   localparam logic [1:0] KIND_FETCH    = 2'd3;

   localparam logic [2:0] ST_ACCEPTED = 3'd0;
   localparam logic [2:0] ST_REJECTED = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_STORED   = 3'd3;
   localparam logic [2:0] ST_DROPPED  = 3'd4;
   localparam logic [2:0] ST_OTHER    = 3'd5;

   typedef struct packed {
      logic capture;
      logic header;
      logic store;
      logic drop;
      logic complete;
      logic tail_write;
      logic fetch;
      logic pump;
      logic load_out;
   } txra_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       rem_zero;
      logic       rem_one;
      logic       mod_done;
   } txra_sts_type;

endpackage

@@ rtl/core/txra_mod.sv @@
// ----------------------------------------------------------------------------
// txra_mod
// Wrap unit for the tail index after a transmit complete: the sum of tail
// and segment length stays below twice the ring size, so one registered
// compare and subtract gives the remainder in the cycle after start.
// ----------------------------------------------------------------------------
module txra_mod (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [txra_pkg::SIZE_W-1:0]   dividend,
   input  logic [txra_pkg::SIZE_W-1:0]   divisor,
   output logic                          done,
   output logic [txra_pkg::IDX_W-1:0]    remainder
);

   logic                        pend_ff, pend_in;
   logic [txra_pkg::SIZE_W-1:0] x_ff, x_in;
   logic [txra_pkg::SIZE_W-1:0] d_ff, d_in;
   logic [txra_pkg::SIZE_W-1:0] reduced;

   always_comb begin
      pend_in = start;
      x_in    = start ? dividend : x_ff;
      d_in    = start ? divisor : d_ff;
      reduced = (x_ff >= d_ff) ? x_ff - d_ff : x_ff;
   end

   assign done      = pend_ff;
   assign remainder = reduced[txra_pkg::IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      d_ff <= d_in;
   end

endmodule

@@ rtl/core/txra_dp.sv @@
// ----------------------------------------------------------------------------
// txra_dp
// Datapath: ring storage, head/tail indices, frame admission arithmetic,
// segment pump and the result word register.
// ----------------------------------------------------------------------------
module txra_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  txra_pkg::txra_cmd_type        cmd,
   output txra_pkg::txra_sts_type        sts,
   input  logic                          csr_write_enable,
   input  logic [txra_pkg::SIZE_W-1:0]   csr_write_data,
   input  logic [1:0]                    req_kind,
   input  logic [10:0]                   req_frame_len,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_transmitter_ready,
   input  logic [9:0]                    req_fetch_index,
   output logic [2:0]                    rsp_status,
   output logic                          rsp_segment_valid,
   output logic [9:0]                    rsp_segment_start,
   output logic [9:0]                    rsp_segment_length,
   output logic [9:0]                    rsp_free_space,
   output logic [7:0]                    rsp_read_data
);

   localparam int IW = txra_pkg::IDX_W;
   localparam int SW = txra_pkg::SIZE_W;

   logic [7:0] mem [txra_pkg::DEPTH];
   logic [7:0] rdata_ff;

   // captured word
   logic [1:0]    kind_ff;
   logic [SW-1:0] flen_ff;
   logic [7:0]    dbyte_ff;
   logic          ready_ff;
   logic [IW-1:0] fidx_ff;

   // ring state
   logic [SW-1:0] size_ff, size_in;
   logic [IW-1:0] head_ff, head_in;
   logic [IW-1:0] tail_ff, tail_in;
   logic          busy_ff, busy_in;
   logic [IW-1:0] seg_ff, seg_in;
   logic [SW-1:0] rem_ff, rem_in;

   // working result
   logic [2:0]    res_status_ff, res_status_in;
   logic          res_seg_valid_ff, res_seg_valid_in;
   logic [IW-1:0] res_seg_start_ff, res_seg_start_in;
   logic [IW-1:0] res_seg_len_ff, res_seg_len_in;
   logic [IW-1:0] res_free_ff, res_free_in;
   logic          res_fetch_ff, res_fetch_in;

   logic [SW-1:0] size_clamped;
   logic [SW-1:0] free_cnt;
   logic [SW-1:0] head_inc;
   logic [SW-1:0] pump_len;
   logic          mod_done;
   logic [IW-1:0] mod_rem;

   txra_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.complete),
      .dividend  ({1'b0, tail_ff} + {1'b0, seg_ff}),
      .divisor   (size_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   always_comb begin
      if (csr_write_data < txra_pkg::SIZE_MIN) begin
         size_clamped = txra_pkg::SIZE_MIN;
      end else if (csr_write_data > txra_pkg::SIZE_MAX) begin
         size_clamped = txra_pkg::SIZE_MAX;
      end else begin
         size_clamped = csr_write_data;
      end
   end

   always_comb begin
      if (tail_ff > head_ff) begin
         free_cnt = {1'b0, tail_ff} - {1'b0, head_ff} - SW'(1);
      end else begin
         free_cnt = size_ff - {1'b0, head_ff} + {1'b0, tail_ff} - SW'(1);
      end
      head_inc = {1'b0, head_ff} + SW'(1);
      if (head_ff > tail_ff) begin
         pump_len = {1'b0, head_ff} - {1'b0, tail_ff};
      end else begin
         pump_len = size_ff - {1'b0, tail_ff};
      end
   end

   always_comb begin
      size_in          = size_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      busy_in          = busy_ff;
      seg_in           = seg_ff;
      rem_in           = rem_ff;
      res_status_in    = res_status_ff;
      res_seg_valid_in = res_seg_valid_ff;
      res_seg_start_in = res_seg_start_ff;
      res_seg_len_in   = res_seg_len_ff;
      res_free_in      = res_free_ff;
      res_fetch_in     = res_fetch_ff;

      if (csr_write_enable) begin
         size_in = size_clamped;
         head_in = '0;
         tail_in = '0;
         busy_in = 1'b0;
         seg_in  = '0;
         rem_in  = '0;
      end else begin
         if (cmd.capture) begin
            res_status_in    = txra_pkg::ST_OTHER;
            res_seg_valid_in = 1'b0;
            res_seg_start_in = '0;
            res_seg_len_in   = '0;
            res_free_in      = '0;
            res_fetch_in     = 1'b0;
         end
         if (cmd.header) begin
            if (flen_ff == '0) begin
               res_status_in = txra_pkg::ST_EMPTY;
            end else begin
               res_free_in = free_cnt[IW-1:0];
               if (flen_ff > free_cnt) begin
                  rem_in        = '0;
                  res_status_in = txra_pkg::ST_REJECTED;
               end else begin
                  rem_in        = flen_ff;
                  res_status_in = txra_pkg::ST_ACCEPTED;
               end
            end
         end
         if (cmd.drop) begin
            res_status_in = txra_pkg::ST_DROPPED;
         end
         if (cmd.store) begin
            head_in       = (head_inc == size_ff) ? '0 : head_inc[IW-1:0];
            rem_in        = rem_ff - SW'(1);
            res_status_in = txra_pkg::ST_STORED;
         end
         if (cmd.complete) begin
            busy_in = 1'b0;
         end
         if (cmd.tail_write) begin
            tail_in = mod_rem;
         end
         if (cmd.fetch) begin
            res_fetch_in = 1'b1;
         end
         if (cmd.pump && !busy_ff && head_ff != tail_ff) begin
            seg_in = pump_len[IW-1:0];
            if (ready_ff) begin
               busy_in          = 1'b1;
               res_seg_valid_in = 1'b1;
               res_seg_start_in = tail_ff;
               res_seg_len_in   = pump_len[IW-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= txra_pkg::SIZE_RESET;
         head_ff <= '0;
         tail_ff <= '0;
         busy_ff <= 1'b0;
         seg_ff  <= '0;
         rem_ff  <= '0;
      end else begin
         size_ff <= size_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         busy_ff <= busy_in;
         seg_ff  <= seg_in;
         rem_ff  <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         flen_ff  <= req_frame_len;
         dbyte_ff <= req_data_byte;
         ready_ff <= req_transmitter_ready;
         fidx_ff  <= req_fetch_index;
      end
      res_status_ff    <= res_status_in;
      res_seg_valid_ff <= res_seg_valid_in;
      res_seg_start_ff <= res_seg_start_in;
      res_seg_len_ff   <= res_seg_len_in;
      res_free_ff      <= res_free_in;
      res_fetch_ff     <= res_fetch_in;
   end

   // ring storage
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[head_ff] <= dbyte_ff;
      end
      if (cmd.fetch) begin
         rdata_ff <= mem[fidx_ff];
      end
   end

   // result word register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status         <= res_status_ff;
         rsp_segment_valid  <= res_seg_valid_ff;
         rsp_segment_start  <= res_seg_start_ff;
         rsp_segment_length <= res_seg_len_ff;
         rsp_free_space     <= res_free_ff;
         rsp_read_data      <= res_fetch_ff ? rdata_ff : 8'd0;
      end
   end

   always_comb begin
      sts.kind     = kind_ff;
      sts.rem_zero = (rem_ff == '0);
      sts.rem_one  = (rem_ff == SW'(1));
      sts.mod_done = mod_done;
   end

   a_head_in_ring: assert property (@(posedge clock) disable iff (reset)
      {1'b0, head_ff} < size_ff)
      else $error("head index beyond ring size");

   a_tail_in_ring: assert property (@(posedge clock) disable iff (reset)
      {1'b0, tail_ff} < size_ff)
      else $error("tail index beyond ring size");

   a_seg_needs_busy: assert property (@(posedge clock) disable iff (reset)
      (cmd.pump && !csr_write_enable && !busy_ff && head_ff != tail_ff && ready_ff)
      |=> busy_ff && res_seg_valid_ff)
      else $error("handed segment did not mark the ring busy");

endmodule

@@ rtl/core/txra_ctrl.sv @@
// ----------------------------------------------------------------------------
// txra_ctrl
// Sequencer: takes one word at a time, steps the datapath through the
// operation of its kind and hands the result to the output register.
// ----------------------------------------------------------------------------
module txra_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output txra_pkg::txra_cmd_type   cmd,
   input  txra_pkg::txra_sts_type   sts
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EXEC = 3'd1;
   localparam logic [2:0] S_MOD  = 3'd2;
   localparam logic [2:0] S_PUMP = 3'd3;
   localparam logic [2:0] S_DONE = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (sts.kind)
               txra_pkg::KIND_HEADER: begin
                  cmd.header = 1'b1;
                  state_in   = S_DONE;
               end
               txra_pkg::KIND_DATA: begin
                  if (sts.rem_zero) begin
                     cmd.drop = 1'b1;
                     state_in = S_DONE;
                  end else begin
                     cmd.store = 1'b1;
                     state_in  = sts.rem_one ? S_PUMP : S_DONE;
                  end
               end
               txra_pkg::KIND_COMPLETE: begin
                  cmd.complete = 1'b1;
                  state_in     = S_MOD;
               end
               txra_pkg::KIND_FETCH: begin
                  cmd.fetch = 1'b1;
                  state_in  = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         S_MOD: begin
            if (sts.mod_done) begin
               cmd.tail_write = 1'b1;
               state_in       = S_PUMP;
            end
         end
         S_PUMP: begin
            cmd.pump = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC)
      else $error("accepted word not executed");

   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> out_free)
      else $error("result word overwritten before it was taken");

   a_mod_done_in_mod: assert property (@(posedge clock) disable iff (reset)
      sts.mod_done |-> state_ff == S_MOD)
      else $error("remainder unit finished outside its wait state");

endmodule

@@ rtl/core/tx_ring_frame_admission.sv @@
// ----------------------------------------------------------------------------
// tx_ring_frame_admission
// Transmit ring buffer with whole-frame admission and contiguous segment
// handoff to a transmitter.
//
// req_* carries one word: a frame header, a data byte, a transmit complete
// or a buffer fetch. rsp_* returns one result word for every request word,
// in order. Both use valid/ready; a word moves when both are high.
// csr_write_* sets the ring size (clamped to 2..1024) and clears head,
// tail, the busy flag, the segment length and any open frame.
// One word is worked on at a time. A header, a fetch and a dropped or
// stored byte go through capture, execute and result load; the last byte
// of a frame adds the segment pump, and a transmit complete adds the
// compare and subtract that wraps the tail index and then the pump.
// The result register parts the two sides: a new word is taken while a
// result waits, and a stalled receiver holds the block only when the next
// result is ready to be written. Reset empties the ring, sets the size to
// 1024 and drops any pending result; ring contents are kept undefined.
// ----------------------------------------------------------------------------
module tx_ring_frame_admission (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [10:0] req_frame_len,
   input  logic [7:0]  req_data_byte,
   input  logic        req_transmitter_ready,
   input  logic [9:0]  req_fetch_index,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic        rsp_segment_valid,
   output logic [9:0]  rsp_segment_start,
   output logic [9:0]  rsp_segment_length,
   output logic [9:0]  rsp_free_space,
   output logic [7:0]  rsp_read_data,
   input  logic        csr_write_enable,
   input  logic [10:0] csr_write_data
);

   txra_pkg::txra_cmd_type cmd;
   txra_pkg::txra_sts_type sts;

   txra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   txra_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .req_kind              (req_kind),
      .req_frame_len         (req_frame_len),
      .req_data_byte         (req_data_byte),
      .req_transmitter_ready (req_transmitter_ready),
      .req_fetch_index       (req_fetch_index),
      .rsp_status            (rsp_status),
      .rsp_segment_valid     (rsp_segment_valid),
      .rsp_segment_start     (rsp_segment_start),
      .rsp_segment_length    (rsp_segment_length),
      .rsp_free_space        (rsp_free_space),
      .rsp_read_data         (rsp_read_data)
   );

endmodule
